// ===== sv/sfbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sfbe_pkg;

	// Memory geometry.
	localparam int FLASH_WORDS = 16384;
	localparam int PAGE_WORDS  = 64;
	localparam int FLASH_AW    = $clog2(FLASH_WORDS);
	localparam int PAGE_AW     = $clog2(PAGE_WORDS);

	// Characters of the host protocol.
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_QUERY = 8'h3F;
	localparam logic [7:0] CH_EXIT  = 8'h58;
	localparam logic [7:0] CH_PROMPT = 8'h70;
	localparam logic [7:0] CMD_ADDR  = 8'h61;
	localparam logic [7:0] CMD_ERASE = 8'h65;
	localparam logic [7:0] CMD_EXIT  = 8'h78;
	localparam logic [7:0] CMD_SIZE  = 8'h73;
	localparam logic [7:0] CMD_WRITE = 8'h77;
	localparam logic [7:0] CMD_READ  = 8'h72;

	// Input opcodes.
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Register indexes.
	localparam logic [1:0] REG_ENTRY   = 2'd0;
	localparam logic [1:0] REG_MAXBLK  = 2'd1;
	localparam logic [1:0] REG_BOOT    = 2'd2;
	localparam logic [1:0] REG_TIMEOUT = 2'd3;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last;
		logic       app_start;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  entry_char;
		logic [8:0]  max_block_bytes;
		logic [15:0] boot_start_byte;
		logic [15:0] timeout_ticks;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                fl_we;
		logic [FLASH_AW-1:0] fl_waddr;
		logic [15:0]         fl_wdata;
		logic                fl_re;
		logic [FLASH_AW-1:0] fl_raddr;
		logic                pb_we;
		logic [PAGE_AW-1:0]  pb_waddr;
		logic [15:0]         pb_wdata;
		logic                pb_re;
		logic [PAGE_AW-1:0]  pb_raddr;
		logic                pb_clr;
		logic                out_load;
		out_item_t           out_data;
	} dp_cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic [15:0] fl_rdata;
		logic [15:0] pb_rdata;
		logic        out_free;
	} dp_status_t;

	function automatic out_item_t mk_res(logic [7:0] tx, logic lst, logic app);
		out_item_t r;
		r.tx_byte   = tx;
		r.last      = lst;
		r.app_start = app;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/sfbe_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sfbe_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sfbe_pkg::dp_cmd_t   cmd,
	output sfbe_pkg::dp_status_t     st,
	input  wire logic                out_stall,
	output logic                     out_valid,
	output sfbe_pkg::out_item_t      out_data
);
	import sfbe_pkg::*;

	logic [15:0]           flash_mem [FLASH_WORDS];
	logic [15:0]           pb_mem [PAGE_WORDS];
	logic [PAGE_WORDS-1:0] pb_vld_q;
	logic [15:0]           fl_rdata_q;
	logic [15:0]           pb_rdata_q;
	logic                  pb_rvld_q;
	logic                  out_valid_q;
	out_item_t             out_data_q;

	// Flash array: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.fl_we) begin
			flash_mem[cmd.fl_waddr] <= cmd.fl_wdata;
		end
		if (cmd.fl_re) begin
			fl_rdata_q <= flash_mem[cmd.fl_raddr];
		end
	end

	// Page buffer storage with registered read.
	always_ff @(posedge clk) begin
		if (cmd.pb_we) begin
			pb_mem[cmd.pb_waddr] <= cmd.pb_wdata;
		end
		if (cmd.pb_re) begin
			pb_rdata_q <= pb_mem[cmd.pb_raddr];
		end
	end

	// An entry that was not written since the last page write reads as erased.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pb_vld_q  <= '0;
			pb_rvld_q <= 1'b0;
		end else begin
			if (cmd.pb_re) begin
				pb_rvld_q <= pb_vld_q[cmd.pb_raddr];
			end
			if (cmd.pb_clr) begin
				pb_vld_q <= '0;
			end else if (cmd.pb_we) begin
				pb_vld_q[cmd.pb_waddr] <= 1'b1;
			end
		end
	end

	// Output register: a result waits here until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= cmd.out_data;
		end
	end

	assign st.fl_rdata = fl_rdata_q;
	assign st.pb_rdata = pb_rvld_q ? pb_rdata_q : 16'hFFFF;
	assign st.out_free = !out_valid_q || !out_stall;
	assign out_valid   = out_valid_q;
	assign out_data    = out_data_q;

endmodule
`default_nettype wire

// ===== sv/sfbe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sfbe_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire sfbe_pkg::in_item_t   in_data,
	input  wire sfbe_pkg::cfg_t       cfg,
	output sfbe_pkg::dp_cmd_t         cmd,
	input  wire sfbe_pkg::dp_status_t st
);
	import sfbe_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_RDWAIT, ST_EMIT, ST_PAGE, ST_ERASE
	} state_t;

	typedef enum logic [3:0] {
		MD_ENTRY, MD_CMD, MD_A_HI, MD_A_LO, MD_WL_HI, MD_WL_LO,
		MD_WD_LO, MD_WD_HI, MD_RL_HI, MD_RL_LO, MD_READ, MD_APP
	} mode_t;

	state_t      state_q;
	mode_t       mode_q;
	logic [15:0] wait_q;
	logic [15:0] cur_q;
	logic [15:0] block_q;
	logic [15:0] left_q;
	logic [7:0]  held_q;
	logic [15:0] sweep_q;
	out_item_t   res0_q;
	out_item_t   res1_q;
	logic        res_two_q;
	logic        res_idx_q;

	logic        acc;
	logic        tick;
	logic [7:0]  b;
	logic [15:0] len;
	logic [15:0] wait_n;
	logic [15:0] left_dec;
	logic [16:0] page_byte;
	logic        erase_go;
	logic [15:0] copy_k;

	assign acc       = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign tick      = (in_data.opcode == OP_TICK);
	assign b         = in_data.data_byte;
	assign len       = {held_q, b};
	assign wait_n    = (wait_q != 16'hFFFF) ? 16'(wait_q + 16'd1) : wait_q;
	assign left_dec  = (left_q != 16'd0) ? 16'(left_q - 16'd1) : 16'd0;
	assign page_byte = {sweep_q[15:PAGE_AW], {PAGE_AW{1'b0}}, 1'b0};
	assign erase_go  = (page_byte < {1'b0, cfg.boot_start_byte});
	assign copy_k    = 16'(sweep_q - 16'd1);

	// Memory and output commands for the datapath.
	always_comb begin
		cmd = '0;
		cmd.fl_wdata = 16'hFFFF;
		case (state_q)
			ST_CLEAR: begin
				cmd.fl_we    = 1'b1;
				cmd.fl_waddr = sweep_q[FLASH_AW-1:0];
			end
			ST_ERASE: begin
				cmd.fl_we    = erase_go;
				cmd.fl_waddr = sweep_q[FLASH_AW-1:0];
			end
			ST_PAGE: begin
				cmd.fl_we    = (sweep_q != 16'd0);
				cmd.fl_waddr = {block_q[FLASH_AW:PAGE_AW+1], copy_k[PAGE_AW-1:0]};
				cmd.fl_wdata = st.pb_rdata;
				cmd.pb_re    = (sweep_q < 16'(PAGE_WORDS));
				cmd.pb_raddr = sweep_q[PAGE_AW-1:0];
				cmd.pb_clr   = (sweep_q == 16'(PAGE_WORDS));
			end
			ST_EMIT: begin
				cmd.out_load = st.out_free;
				cmd.out_data = res_idx_q ? res1_q : res0_q;
			end
			ST_IDLE: begin
				cmd.fl_re    = acc && (mode_q == MD_READ) && tick;
				cmd.fl_raddr = cur_q[FLASH_AW:1];
				cmd.pb_we    = acc && (mode_q == MD_WD_HI) && !tick;
				cmd.pb_waddr = cur_q[PAGE_AW:1];
				cmd.pb_wdata = {b, held_q};
			end
			default: begin
				cmd.fl_we = 1'b0;
			end
		endcase
	end

	// Sequencer and protocol state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			mode_q    <= MD_ENTRY;
			wait_q    <= '0;
			cur_q     <= '0;
			block_q   <= '0;
			left_q    <= '0;
			held_q    <= '0;
			sweep_q   <= '0;
			res0_q    <= '0;
			res1_q    <= '0;
			res_two_q <= 1'b0;
			res_idx_q <= 1'b0;
		end else begin
			case (state_q)
				// Flash is set to the erased value after reset.
				ST_CLEAR: begin
					if (sweep_q == 16'(FLASH_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
					sweep_q <= 16'(sweep_q + 16'd1);
				end
				ST_RDWAIT: begin
					res0_q    <= mk_res(st.fl_rdata[7:0], 1'b0, 1'b0);
					res1_q    <= mk_res(st.fl_rdata[15:8], 1'b1, 1'b0);
					res_two_q <= 1'b1;
					res_idx_q <= 1'b0;
					state_q   <= ST_EMIT;
				end
				ST_EMIT: begin
					if (st.out_free) begin
						if (res_idx_q || !res_two_q) begin
							state_q <= ST_IDLE;
						end
						res_idx_q <= 1'b1;
					end
				end
				// Copy the page buffer into flash, one word a cycle.
				ST_PAGE: begin
					if (sweep_q == 16'(PAGE_WORDS)) begin
						state_q <= ST_EMIT;
					end
					sweep_q <= 16'(sweep_q + 16'd1);
				end
				// Erase every word of the pages that start below the boot start address.
				ST_ERASE: begin
					if (erase_go) begin
						sweep_q <= 16'(sweep_q + 16'd1);
					end else begin
						cur_q   <= page_byte[15:0];
						state_q <= ST_EMIT;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						res_idx_q <= 1'b0;
						res_two_q <= 1'b0;
						sweep_q   <= '0;
						case (mode_q)
							MD_APP: begin
								mode_q <= MD_APP;
							end
							MD_ENTRY: begin
								if (tick) begin
									wait_q <= wait_n;
									if (wait_n >= cfg.timeout_ticks) begin
										mode_q  <= MD_APP;
										res0_q  <= mk_res(CH_EXIT, 1'b1, 1'b1);
										state_q <= ST_EMIT;
									end
								end else if (b == cfg.entry_char) begin
									mode_q  <= MD_CMD;
									res0_q  <= mk_res(CH_PROMPT, 1'b1, 1'b0);
									state_q <= ST_EMIT;
								end
							end
							MD_READ: begin
								if (tick) begin
									cur_q   <= 16'(cur_q + 16'd2);
									left_q  <= left_dec;
									state_q <= ST_RDWAIT;
									if (left_dec == 16'd0) begin
										mode_q <= MD_CMD;
									end
								end
							end
							default: begin
								if (!tick) begin
									case (mode_q)
										MD_CMD: begin
											case (b)
												CMD_ADDR:  mode_q <= MD_A_HI;
												CMD_WRITE: mode_q <= MD_WL_HI;
												CMD_READ:  mode_q <= MD_RL_HI;
												CMD_ERASE: begin
													res0_q  <= mk_res(CH_CR, 1'b1, 1'b0);
													state_q <= ST_ERASE;
												end
												CMD_SIZE: begin
													res0_q <= mk_res({7'd0, cfg.max_block_bytes[8]},
														1'b0, 1'b0);
													res1_q <= mk_res(cfg.max_block_bytes[7:0],
														1'b1, 1'b0);
													res_two_q <= 1'b1;
													state_q   <= ST_EMIT;
												end
												CMD_EXIT: begin
													mode_q  <= MD_APP;
													res0_q  <= mk_res(CH_EXIT, 1'b1, 1'b1);
													state_q <= ST_EMIT;
												end
												default: begin
													res0_q  <= mk_res(CH_QUERY, 1'b1, 1'b0);
													state_q <= ST_EMIT;
												end
											endcase
										end
										MD_A_HI, MD_WL_HI, MD_WD_LO, MD_RL_HI: begin
											held_q <= b;
											case (mode_q)
												MD_A_HI:  mode_q <= MD_A_LO;
												MD_WL_HI: mode_q <= MD_WL_LO;
												MD_WD_LO: mode_q <= MD_WD_HI;
												default:  mode_q <= MD_RL_LO;
											endcase
										end
										MD_A_LO: begin
											cur_q   <= {len[14:0], 1'b0};
											mode_q  <= MD_CMD;
											res0_q  <= mk_res(CH_CR, 1'b1, 1'b0);
											state_q <= ST_EMIT;
										end
										MD_WL_LO: begin
											if (len > {7'd0, cfg.max_block_bytes}) begin
												mode_q  <= MD_CMD;
												res0_q  <= mk_res(CH_QUERY, 1'b1, 1'b0);
												state_q <= ST_EMIT;
											end else begin
												block_q <= cur_q;
												left_q  <= {1'b0, len[15:1]};
												if (len[15:1] == 15'd0) begin
													// Empty block: the page is written at once.
													mode_q  <= MD_CMD;
													state_q <= ST_PAGE;
													if (cur_q > cfg.boot_start_byte) begin
														res0_q    <= mk_res(8'd0, 1'b0, 1'b0);
														res1_q    <= mk_res(CH_CR, 1'b1, 1'b0);
														res_two_q <= 1'b1;
													end else begin
														res0_q <= mk_res(CH_CR, 1'b1, 1'b0);
													end
												end else begin
													mode_q <= MD_WD_LO;
													if (cur_q > cfg.boot_start_byte) begin
														res0_q  <= mk_res(8'd0, 1'b1, 1'b0);
														state_q <= ST_EMIT;
													end
												end
											end
										end
										MD_WD_HI: begin
											cur_q  <= 16'(cur_q + 16'd2);
											left_q <= left_dec;
											if (left_dec == 16'd0) begin
												mode_q  <= MD_CMD;
												res0_q  <= mk_res(CH_CR, 1'b1, 1'b0);
												state_q <= ST_PAGE;
											end else begin
												mode_q <= MD_WD_LO;
											end
										end
										MD_RL_LO: begin
											left_q <= 16'((17'(len) + 17'd1) >> 1);
											mode_q <= (len == 16'd0) ? MD_CMD : MD_READ;
										end
										default: begin
											mode_q <= MD_CMD;
										end
									endcase
								end
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/serial_flash_bootloader_engine_unit.sv =====
// Serial bootloader protocol engine.
// Input channel (in_valid, in_stall, in_data): each transfer is a byte received
// from the host or a time tick, which also serves as a transmit slot for reads.
// Output channel (out_valid, out_stall, out_data): bytes sent back to the host,
// with last set on the final byte caused by one input and app_start set on the
// 'X' that hands control to the application. An input causes zero to two bytes.
// Configuration registers sit on the APB port at byte addresses 0, 4, 8 and 12.
// Sequencing: a plain command byte is accepted in the idle state, and each result
// byte is then loaded into the output register once it is free. A read tick adds a
// wait state for the registered flash read. A page write walks the page buffer into
// flash, and an erase walks every word of the pages that start below the boot start
// address, one word a cycle, so its length follows the boot start address.
// After reset the engine sets every word of the flash array to the erased value,
// and holds in_stall high meanwhile.
// The next input is taken while the last result still waits in the output
// register; a stalled receiver holds the engine once another result is due.
`timescale 1ns / 1ps
`default_nettype none
module serial_flash_bootloader_engine_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire sfbe_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output sfbe_pkg::out_item_t      out_data,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [3:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);
	import sfbe_pkg::*;

	cfg_t       cfg_q;
	dp_cmd_t    cmd;
	dp_status_t st;

	assign pready = 1'b1;

	// Register file write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entry_char      <= 8'd83;
			cfg_q.max_block_bytes <= 9'd128;
			cfg_q.boot_start_byte <= 16'd28672;
			cfg_q.timeout_ticks   <= 16'd1000;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_ENTRY:   cfg_q.entry_char      <= pwdata[7:0];
				REG_MAXBLK:  cfg_q.max_block_bytes <= pwdata[8:0];
				REG_BOOT:    cfg_q.boot_start_byte <= pwdata[15:0];
				REG_TIMEOUT: cfg_q.timeout_ticks   <= pwdata[15:0];
				default:     cfg_q.entry_char      <= cfg_q.entry_char;
			endcase
		end
	end

	// Register file read.
	always_comb begin
		case (paddr[3:2])
			REG_ENTRY:   prdata = {24'd0, cfg_q.entry_char};
			REG_MAXBLK:  prdata = {23'd0, cfg_q.max_block_bytes};
			REG_BOOT:    prdata = {16'd0, cfg_q.boot_start_byte};
			REG_TIMEOUT: prdata = {16'd0, cfg_q.timeout_ticks};
			default:     prdata = '0;
		endcase
	end

	sfbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.st       (st)
	);

	sfbe_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import sfbe_pkg::*;

	localparam int WATCHDOG_LIMIT = 100000;
	localparam int HOLD_CYCLES    = 3000;
	localparam int SETTLE_CYCLES  = 200;

	typedef enum logic [3:0] {
		MD_ENTRY, MD_CMD, MD_A_HI, MD_A_LO, MD_WL_HI, MD_WL_LO, MD_WD_LO, MD_WD_HI,
		MD_RL_HI, MD_RL_LO, MD_READ, MD_APP
	} boot_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	serial_flash_bootloader_engine_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stimulus and expected traffic.
	in_item_t  host_items[$];
	out_item_t replies_due[$];
	int        failures = 0;
	bit        idle_en = 1'b1;
	int        hold_req = 0;

	// Shadow of the engine: configuration, protocol state and memories.
	cfg_t        cfg_shadow;
	boot_mode_t  bl_mode;
	logic [15:0] wait_cnt, addr_q, blk_start, remain;
	logic [7:0]  held;
	logic [15:0] page_buf[PAGE_WORDS];
	logic [15:0] flash_img[FLASH_WORDS];

	// Generator bookkeeping.
	logic [8:0]  gen_max;
	logic [15:0] addr_pool[8];
	bit          erase_ok;

	function automatic void reply(logic [7:0] tx, logic lst, logic app);
		replies_due.push_back(out_item_t'{tx_byte: tx, last: lst, app_start: app});
	endfunction

	function automatic void commit_page();
		int base;
		base = ((blk_start >> 1) / PAGE_WORDS) * PAGE_WORDS;
		for (int k = 0; k < PAGE_WORDS; k++) begin
			flash_img[(base + k) % FLASH_WORDS] = page_buf[k];
			page_buf[k] = 16'hFFFF;
		end
	endfunction

	// Advance the shadow engine by one accepted transfer.
	function automatic void predict_reply(in_item_t it);
		logic        tick;
		logic [7:0]  b;
		logic [16:0] len;
		logic [15:0] w;
		int          a;
		tick = (it.opcode == OP_TICK);
		b = it.data_byte;
		case (bl_mode)
			MD_APP: ;
			MD_ENTRY: begin
				if (tick) begin
					if (wait_cnt != 16'hFFFF) wait_cnt++;
					if (wait_cnt >= cfg_shadow.timeout_ticks) begin
						bl_mode = MD_APP;
						reply(CH_EXIT, 1'b1, 1'b1);
					end
				end else if (b == cfg_shadow.entry_char) begin
					bl_mode = MD_CMD;
					reply(CH_PROMPT, 1'b1, 1'b0);
				end
			end
			MD_READ: begin
				if (tick) begin
					w = flash_img[(addr_q >> 1) % FLASH_WORDS];
					reply(w[7:0], 1'b0, 1'b0);
					reply(w[15:8], 1'b1, 1'b0);
					addr_q = addr_q + 16'd2;
					if (remain > 0) remain--;
					if (remain == 0) bl_mode = MD_CMD;
				end
			end
			default: if (!tick) begin
				case (bl_mode)
					MD_CMD: begin
						case (b)
							CMD_ADDR:  bl_mode = MD_A_HI;
							CMD_WRITE: bl_mode = MD_WL_HI;
							CMD_READ:  bl_mode = MD_RL_HI;
							CMD_ERASE: begin
								for (a = 0; a < cfg_shadow.boot_start_byte; a += 2 * PAGE_WORDS)
									for (int k = 0; k < PAGE_WORDS; k++)
										flash_img[((a >> 1) + k) % FLASH_WORDS] = 16'hFFFF;
								addr_q = a[15:0];
								reply(CH_CR, 1'b1, 1'b0);
							end
							CMD_SIZE: begin
								reply({7'd0, cfg_shadow.max_block_bytes[8]}, 1'b0, 1'b0);
								reply(cfg_shadow.max_block_bytes[7:0], 1'b1, 1'b0);
							end
							CMD_EXIT: begin
								bl_mode = MD_APP;
								reply(CH_EXIT, 1'b1, 1'b1);
							end
							default: reply(CH_QUERY, 1'b1, 1'b0);
						endcase
					end
					MD_A_HI: begin
						held = b;
						bl_mode = MD_A_LO;
					end
					MD_A_LO: begin
						addr_q = {held[6:0], b, 1'b0};
						bl_mode = MD_CMD;
						reply(CH_CR, 1'b1, 1'b0);
					end
					MD_WL_HI: begin
						held = b;
						bl_mode = MD_WL_LO;
					end
					MD_WL_LO: begin
						len = {1'b0, held, b};
						if (len > cfg_shadow.max_block_bytes) begin
							bl_mode = MD_CMD;
							reply(CH_QUERY, 1'b1, 1'b0);
						end else begin
							blk_start = addr_q;
							remain = len[16:1];
							// The zero answer is final only when data bytes follow.
							if (addr_q > cfg_shadow.boot_start_byte)
								reply(8'd0, remain != 16'd0, 1'b0);
							if (remain == 0) begin
								commit_page();
								bl_mode = MD_CMD;
								reply(CH_CR, 1'b1, 1'b0);
							end else begin
								bl_mode = MD_WD_LO;
							end
						end
					end
					MD_WD_LO: begin
						held = b;
						bl_mode = MD_WD_HI;
					end
					MD_WD_HI: begin
						page_buf[(addr_q >> 1) % PAGE_WORDS] = {b, held};
						addr_q = addr_q + 16'd2;
						if (remain > 0) remain--;
						if (remain == 0) begin
							commit_page();
							bl_mode = MD_CMD;
							reply(CH_CR, 1'b1, 1'b0);
						end else begin
							bl_mode = MD_WD_LO;
						end
					end
					MD_RL_HI: begin
						held = b;
						bl_mode = MD_RL_LO;
					end
					MD_RL_LO: begin
						len = {1'b0, held, b} + 17'd1;
						remain = len[16:1];
						bl_mode = (remain == 0) ? MD_CMD : MD_READ;
					end
					default: bl_mode = MD_CMD;
				endcase
			end
		endcase
	endfunction

	// Input driver: offers queued transfers with random gaps.
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			gap_left <= 0;
		end else if (!(in_valid && in_stall)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (host_items.size() > 0) begin
				in_valid <= 1'b1;
				in_data  <= host_items.pop_front();
				if (idle_en && $urandom_range(0, 9) == 0) gap_left <= $urandom_range(1, 19);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Each accepted transfer updates the shadow engine.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) predict_reply(in_data);
	end

	// Output stall: random bursts, plus long holds on request.
	int stall_left, hold_seen;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
			hold_seen  <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen  <= hold_req;
			stall_left <= HOLD_CYCLES;
			out_stall  <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (idle_en && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 18);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Output monitor: compare each transfer with the oldest expected reply.
	out_item_t due;
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (replies_due.size() == 0) begin
				$error("unexpected reply tx_byte=%h", out_data.tx_byte);
				failures++;
			end else begin
				due = replies_due.pop_front();
				if (out_data.tx_byte !== due.tx_byte) begin
					$error("tx_byte: expected %h, actual %h", due.tx_byte, out_data.tx_byte);
					failures++;
				end
				if (out_data.last !== due.last) begin
					$error("last: expected %b, actual %b", due.last, out_data.last);
					failures++;
				end
				if (out_data.app_start !== due.app_start) begin
					$error("app_start: expected %b, actual %b", due.app_start,
						out_data.app_start);
					failures++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_ENTRY:   cfg_shadow.entry_char      = v[7:0];
			REG_MAXBLK:  cfg_shadow.max_block_bytes = v[8:0];
			REG_BOOT:    cfg_shadow.boot_start_byte = v[15:0];
			REG_TIMEOUT: cfg_shadow.timeout_ticks   = v[15:0];
			default: ;
		endcase
		if (idx == REG_MAXBLK) gen_max = v[8:0];
	endtask

	task automatic drain();
		while (host_items.size() > 0 || in_valid || replies_due.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_byte(logic [7:0] b);
		host_items.push_back(in_item_t'{opcode: OP_BYTE, data_byte: b});
	endtask

	task automatic send_tick();
		host_items.push_back(in_item_t'{opcode: OP_TICK, data_byte: 8'($urandom)});
	endtask

	task automatic send_addr(logic [15:0] word_addr);
		send_byte(CMD_ADDR);
		send_byte(word_addr[15:8]);
		send_byte(word_addr[7:0]);
	endtask

	// Write command; a rejected length leaves the data bytes out.
	task automatic send_write(logic [15:0] len);
		send_byte(CMD_WRITE);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		if (len <= gen_max)
			for (int k = 0; k < 2 * (len >> 1); k++) send_byte(8'($urandom));
	endtask

	// Read command; bytes mixed into the stream are dropped by the engine.
	task automatic send_read(logic [7:0] len);
		send_byte(CMD_READ);
		send_byte(8'd0);
		send_byte(len);
		for (int k = 0; k < (len + 1) / 2; k++) begin
			if ($urandom_range(0, 3) == 0) send_byte(8'($urandom));
			send_tick();
		end
	endtask

	task automatic send_unknown();
		logic [7:0] b;
		b = 8'($urandom);
		while (b inside {CMD_ADDR, CMD_ERASE, CMD_EXIT, CMD_SIZE, CMD_WRITE, CMD_READ})
			b = 8'($urandom);
		send_byte(b);
	endtask

	// Random traffic, mostly complete commands with random content.
	task automatic send_mix(int count);
		int r, base;
		logic [15:0] len;
		base = host_items.size();
		while (host_items.size() - base < count) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				if ($urandom_range(0, 9) == 0) len = gen_max + 16'd1;
				else len = 16'($urandom_range(0, gen_max));
				if ($urandom_range(0, 3) != 0) len = 16'($urandom_range(0, 24));
				send_write(len);
			end else if (r < 52) begin
				send_read($urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(0, 16)));
			end else if (r < 66) begin
				send_addr(addr_pool[$urandom_range(0, 7)]);
			end else if (r < 73) begin
				send_byte(CMD_SIZE);
			end else if (r < 75 && erase_ok) begin
				send_byte(CMD_ERASE);
			end else if (r < 88) begin
				send_unknown();
			end else begin
				send_tick();
			end
		end
	endtask

	initial begin
		logic [7:0] entry;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		cfg_shadow = '{entry_char: 8'd83, max_block_bytes: 9'd128,
			boot_start_byte: 16'd28672, timeout_ticks: 16'd1000};
		gen_max  = 9'd128;
		bl_mode  = MD_ENTRY;
		wait_cnt = '0;
		addr_q   = '0;
		blk_start = '0;
		remain   = '0;
		held     = '0;
		foreach (page_buf[k]) page_buf[k] = 16'hFFFF;
		foreach (flash_img[k]) flash_img[k] = 16'hFFFF;
		addr_pool[0] = 16'h0000;
		addr_pool[1] = 16'hFFFF;
		for (int k = 2; k < 8; k++) addr_pool[k] = 16'($urandom);
		erase_ok = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Entry wait: ticks below the timeout and wrong bytes are dropped.
		entry = 8'($urandom);
		reg_write(REG_ENTRY, {24'd0, entry});
		reg_write(REG_TIMEOUT, 32'd65535);
		reg_write(REG_MAXBLK, 32'd256);
		reg_write(REG_BOOT, 32'd1000);
		send_tick();
		send_byte(~entry);
		send_tick();
		send_byte(entry ^ 8'h01);
		send_byte(entry);

		// Directed commands in command mode.
		send_tick();
		send_byte(CMD_SIZE);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_addr(16'hFFFF);
		send_write(16'd0);
		send_addr(16'h0010);
		send_write(16'd1);
		send_write(16'd257);
		send_write(16'd4);
		send_addr(16'h0010);
		send_read(8'd0);
		send_read(8'd3);
		send_byte(CMD_ERASE);
		send_read(8'd2);
		drain();

		// Smallest limits.
		reg_write(REG_MAXBLK, 32'd0);
		reg_write(REG_BOOT, 32'd0);
		reg_write(REG_TIMEOUT, 32'd1);
		reg_write(REG_ENTRY, 32'd0);
		send_mix(300);
		drain();

		// Largest boot section; the receiver holds off for a while.
		reg_write(REG_MAXBLK, 32'd256);
		reg_write(REG_BOOT, 32'd65535);
		reg_write(REG_ENTRY, 32'd255);
		hold_req++;
		send_mix(500);
		drain();

		// Random limits; the last stretch runs without idling.
		reg_write(REG_MAXBLK, $urandom_range(2, 255));
		reg_write(REG_BOOT, $urandom_range(0, 65535));
		reg_write(REG_TIMEOUT, $urandom_range(1, 65535));
		send_mix(600);
		drain();
		idle_en = 1'b0;
		send_mix(400);

		// Handover to the application; everything after it is ignored.
		send_byte(CMD_EXIT);
		send_byte(CMD_SIZE);
		send_tick();
		send_byte(8'($urandom));
		drain();

		if (failures == 0 && replies_due.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
